// File: rtl/rdf_pkg.sv
// shared constants and the symbol lookup for the radix digit formatter
// no dependencies
`default_nettype none

package rdf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_BASE    = 16;
    localparam int BUF_DEPTH   = 32;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int CNT_W       = BUF_AW + 1;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int BASE_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HI  = 2'd2;

    // reset values of the registers
    localparam logic [BASE_W-1:0]     RADIX_RST     = 5'd10;
    localparam logic [CFG_DATA_W-1:0] CHARS_LO_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] CHARS_HI_RST  = 64'h0000000000003938;

    // character codes
    localparam logic [SYM_W-1:0] MINUS_CODE    = 8'd45;
    localparam logic [SYM_W-1:0] PLUS_CODE     = 8'd43;
    localparam logic [SYM_W-1:0] LOW_PRINTABLE = 8'd32;
    localparam logic [SYM_W-1:0] DEL_CODE      = 8'd127;

    // byte of symbol idx out of the two alphabet words
    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[idx[2:0]*SYM_W +: SYM_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/radix_digit_formatter_core.sv
// radix digit formatter: signed integer to character stream in a configurable radix
// depends on rdf_pkg
`default_nettype none

// Takes one signed 32-bit value per request on the slave stream and sends its text, one
// character per request, on the master stream: a minus sign first for a negative value,
// then the digits most significant first, tlast on the final character. The digit
// alphabet (radix 2..16) lives in three configuration registers; the user must write
// them only while the block is idle, and the block itself does not enforce this. An
// invalid alphabet makes the value produce no characters at all. The block takes one
// value at a time and is not ready until its last character has been taken. Per value
// it checks the alphabet, up to radix*(radix+1)/2 symbol pairs, one pair of symbols per
// cycle; then it forms up to 32 digits on a single shared restoring-division step; then
// it sends a minus sign from the output register and each digit character through the
// digit buffer read and the output register, waiting out any stall on the master side.
// The worst case is the most negative value in radix 2.
module radix_digit_formatter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream, tdata: value[31:0]
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rdf_pkg::VALUE_WIDTH-1:0] s_axis_tdata,
    // master stream, tdata: char_code[7:0]; tlast: last_char
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [rdf_pkg::SYM_W-1:0]            m_axis_tdata,
    output logic                                 m_axis_tlast,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rdf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rdf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for a value
        ST_CHECK = 6'b000010,   // alphabet check, one symbol pair per cycle
        ST_DIV   = 6'b000100,   // one restoring division step per cycle
        ST_RD    = 6'b001000,   // digit buffer read issued
        ST_LOAD  = 6'b010000,   // read data back, load output register
        ST_WAIT  = 6'b100000    // character waiting to be taken
    } t_state;

    // configuration registers
    logic [BASE_W-1:0]     r_radix;
    logic [CFG_DATA_W-1:0] r_chars_lo;
    logic [CFG_DATA_W-1:0] r_chars_hi;

    // sequencer and datapath registers
    t_state                 r_state, n_state;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;        // dividend, becomes the quotient
    logic [DIGIT_W-1:0]     r_rem, n_rem;        // running remainder
    logic [STEP_W-1:0]      r_step, n_step;      // division bit counter
    logic [CNT_W-1:0]       r_cnt, n_cnt;        // digits in the buffer
    logic [DIGIT_W-1:0]     r_ci, n_ci;          // alphabet check, first symbol
    logic [DIGIT_W-1:0]     r_cj, n_cj;          // alphabet check, second symbol
    logic                   r_out_valid, n_out_valid;
    logic [SYM_W-1:0]       r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;

    // digit buffer, least significant digit at index 0
    logic [DIGIT_W-1:0] r_buf [BUF_DEPTH];
    logic [DIGIT_W-1:0] r_rd_data;
    logic [BUF_AW-1:0]  w_rd_addr;
    logic               w_we;
    logic [DIGIT_W-1:0] w_wdata;

    // shared division step
    logic [BASE_W-1:0]      w_partial;
    logic                   w_qbit;
    logic [DIGIT_W-1:0]     w_rem_next;
    logic [VALUE_WIDTH-1:0] w_quot_next;

    // alphabet check unit
    logic [SYM_W-1:0]  w_sym_i, w_sym_j;
    logic [BASE_W-1:0] w_last_idx;
    logic              w_base_bad, w_pair_bad;

    logic [VALUE_WIDTH-1:0] w_in_mag;
    logic                   w_in_take, w_out_take;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign w_out_take = r_out_valid && m_axis_tready;

    // magnitude of the two's complement input, most negative value included
    assign w_in_mag = s_axis_tdata[VALUE_WIDTH-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

    // restoring division: shift in the next dividend bit, subtract radix if it fits
    assign w_partial   = {r_rem, r_mag[VALUE_WIDTH-1]};
    assign w_qbit      = (w_partial >= r_radix);
    assign w_rem_next  = w_qbit ? DIGIT_W'(w_partial - r_radix) : w_partial[DIGIT_W-1:0];
    assign w_quot_next = {r_mag[VALUE_WIDTH-2:0], w_qbit};

    // alphabet check: ci == cj checks the symbol range, otherwise a duplicate
    assign w_sym_i    = symbol_at(r_chars_lo, r_chars_hi, r_ci);
    assign w_sym_j    = symbol_at(r_chars_lo, r_chars_hi, r_cj);
    assign w_last_idx = r_radix - 1'b1;
    assign w_base_bad = (r_radix < BASE_W'(2)) || (r_radix > BASE_W'(MAX_BASE));
    always_comb begin
        if (r_ci == r_cj) begin
            w_pair_bad = (w_sym_i < LOW_PRINTABLE) || (w_sym_i >= DEL_CODE)
                      || (w_sym_i == PLUS_CODE) || (w_sym_i == MINUS_CODE);
        end else begin
            w_pair_bad = (w_sym_i == w_sym_j);
        end
    end

    // buffer is read from the top digit down
    assign w_rd_addr = BUF_AW'(r_cnt - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_wdata     = w_rem_next;

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_neg   = s_axis_tdata[VALUE_WIDTH-1];
                    n_mag   = w_in_mag;
                    n_ci    = '0;
                    n_cj    = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_base_bad || w_pair_bad) begin
                    // invalid alphabet: drop the value silently
                    n_state = ST_IDLE;
                end else if ({1'b0, r_cj} == w_last_idx) begin
                    if ({1'b0, r_ci} == w_last_idx) begin
                        n_rem   = '0;
                        n_step  = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end else begin
                        n_ci = r_ci + 1'b1;
                        n_cj = r_ci + 1'b1;
                    end
                end else begin
                    n_cj = r_cj + 1'b1;
                end
            end
            ST_DIV: begin
                n_rem  = w_rem_next;
                n_mag  = w_quot_next;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_WIDTH - 1)) begin
                    // digit complete: store it, then divide again or start output
                    w_we  = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_rem = '0;
                    if ((w_quot_next != '0) && (r_cnt != CNT_W'(BUF_DEPTH - 1))) begin
                        n_state = ST_DIV;
                    end else if (r_neg) begin
                        n_out_valid = 1'b1;
                        n_out_data  = MINUS_CODE;
                        n_out_last  = 1'b0;
                        n_state     = ST_WAIT;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_out_valid = 1'b1;
                n_out_data  = symbol_at(r_chars_lo, r_chars_hi, r_rd_data);
                n_out_last  = (r_cnt == CNT_W'(1));
                n_cnt       = r_cnt - 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_out_take) begin
                    n_out_valid = 1'b0;
                    n_state     = (r_cnt == '0) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mag       <= '0;
            r_cnt       <= '0;
            r_radix     <= RADIX_RST;
            r_chars_lo  <= CHARS_LO_RST;
            r_chars_hi  <= CHARS_HI_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mag       <= n_mag;
            r_cnt       <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIX:     r_radix     <= i_cfg_data[BASE_W-1:0];
                    REG_CHARS_LO:  r_chars_lo  <= i_cfg_data;
                    REG_CHARS_HI:  r_chars_hi  <= i_cfg_data;
                    default: ;    // index beyond the list, ignored
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_ci       <= n_ci;
        r_cj       <= n_cj;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // digit buffer memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[r_cnt[BUF_AW-1:0]] <= w_wdata;
        end
        r_rd_data <= r_buf[w_rd_addr];
    end

endmodule

`default_nettype wire

// File: test/radix_digit_formatter_core_tb.sv
// self-checking testbench for radix_digit_formatter_core: random and directed values
// in random alphabets, predicted character by character and checked in order
// depends on rdf_pkg and rtl/radix_digit_formatter_core.sv
`default_nettype none

typedef struct packed {
    logic [7:0] code;
    logic       last;
} glyph_t;

// holds the register image and the characters still owed by the block
class text_scoreboard;
    logic [4:0]  radix;
    logic [63:0] lo;
    logic [63:0] hi;
    glyph_t      pending[$];
    int          errors;

    function new();
        radix  = rdf_pkg::RADIX_RST;
        lo     = rdf_pkg::CHARS_LO_RST;
        hi     = rdf_pkg::CHARS_HI_RST;
        errors = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [63:0] data);
        case (idx)
            rdf_pkg::REG_RADIX:     radix = data[4:0];
            rdf_pkg::REG_CHARS_LO:  lo = data;
            rdf_pkg::REG_CHARS_HI:  hi = data;
            default: ;
        endcase
    endfunction

    function logic [7:0] glyph(input int idx);
        return (idx < 8) ? lo[8*idx +: 8] : hi[8*(idx-8) +: 8];
    endfunction

    function bit alphabet_valid();
        logic [7:0] c;
        if (radix < 2 || radix > rdf_pkg::MAX_BASE) return 1'b0;
        for (int i = 0; i < radix; i++) begin
            c = glyph(i);
            if (c < rdf_pkg::LOW_PRINTABLE || c >= rdf_pkg::DEL_CODE ||
                c == rdf_pkg::PLUS_CODE || c == rdf_pkg::MINUS_CODE) return 1'b0;
            for (int j = 0; j < i; j++)
                if (glyph(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // accepted value: queue its text, sign first, digits most significant first
    function void note_value(input logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] rdx;
        logic [3:0]  digits[$];
        if (!alphabet_valid()) return;
        rdx = {27'd0, radix};
        mag = v[31] ? -v : v;
        do begin
            digits.push_front(4'(mag % rdx));
            mag = mag / rdx;
        end while (mag != 0);
        if (v[31]) pending.push_back(glyph_t'{code: rdf_pkg::MINUS_CODE, last: 1'b0});
        foreach (digits[k])
            pending.push_back(glyph_t'{code: glyph(digits[k]),
                                       last: (k == digits.size() - 1)});
    endfunction

    function void check_char(input logic [7:0] code, input logic last);
        glyph_t want;
        if (pending.size() == 0) begin
            $error("unexpected character: char_code %0d, last_char %0b", code, last);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (code !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, code);
            errors++;
        end
        if (last !== want.last) begin
            $error("last_char: expected %0b, actual %0b", want.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rdf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RANDOM_ITEMS  = 370;

    typedef enum {
        FAULT_NONE, FAULT_FEW, FAULT_MANY, FAULT_CTRL,
        FAULT_HIGH, FAULT_PLUS, FAULT_MINUS, FAULT_DUP
    } fault_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_WIDTH-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SYM_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    text_scoreboard sb;
    bit calm = 1'b0;      // no random idling on either side while set; a requested hold-off still applies
    bit hold_req = 1'b0;  // asks the receiver for one long hold-off

    radix_digit_formatter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    // character sink: check on handshake, then pick next cycle's tready
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_char(m_axis_tdata, m_axis_tlast);
            if (hold_req && stall_left == 0) begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    // leaves tvalid high on return so back-to-back requests need no second assignment
    task automatic send_value(input logic [31:0] v);
        while (!calm && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_value(v);
    endtask

    // drop tvalid, wait for every owed character, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // radix with random upper bits, both alphabet words, and a stray index
    task automatic program_alphabet(input logic [4:0] n, input logic [127:0] syms);
        logic [63:0] word;
        logic [1:0]  idx;
        for (int r = 0; r < 4; r++) begin
            case (r)
                0: begin
                    word = {$urandom(), $urandom()};
                    word[4:0] = n;
                    idx = REG_RADIX;
                end
                1: begin word = syms[63:0];   idx = REG_CHARS_LO; end
                2: begin word = syms[127:64]; idx = REG_CHARS_HI; end
                default: begin word = {$urandom(), $urandom()}; idx = REG_UNUSED; end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= word;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx, word);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // distinct printable symbols below the radix, anything above it
    function automatic logic [127:0] random_symbols(input logic [4:0] radix);
        logic [127:0] syms;
        logic [127:0] used;
        logic [7:0]   c;
        used = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < radix) begin
                do c = 8'($urandom_range(32, 126));
                while (c == PLUS_CODE || c == MINUS_CODE || used[c]);
                used[c] = 1'b1;
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            syms[8*i +: 8] = c;
        end
        return syms;
    endfunction

    task automatic program_faulty(input fault_e kind, input logic [4:0] radix);
        logic [127:0] syms;
        logic [4:0]   n;
        int           pos;
        int           src;
        n    = radix;
        syms = random_symbols(radix);
        pos  = $urandom_range(1, radix - 1);
        src  = $urandom_range(0, pos - 1);
        if ($urandom_range(1)) pos = src;
        case (kind)
            FAULT_FEW:   n = 5'($urandom_range(0, 1));
            FAULT_MANY:  n = 5'($urandom_range(MAX_BASE + 1, 31));
            FAULT_CTRL:  syms[8*pos +: 8] = 8'($urandom_range(0, 31));
            FAULT_HIGH:  syms[8*pos +: 8] = 8'($urandom_range(127, 255));
            FAULT_PLUS:  syms[8*pos +: 8] = PLUS_CODE;
            FAULT_MINUS: syms[8*pos +: 8] = MINUS_CODE;
            FAULT_DUP: begin
                pos = $urandom_range(1, radix - 1);
                src = $urandom_range(0, pos - 1);
                syms[8*pos +: 8] = syms[8*src +: 8];
            end
            default: ;
        endcase
        program_alphabet(n, syms);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1: begin
                v = $urandom_range(0, 300);
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    default: v = 32'h0;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial begin
        logic [127:0] syms;
        logic [4:0]   radix;
        int           sent;
        int           phase;
        int           count;
        bit           faulty;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // decimal alphabet straight out of reset
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        settle();

        // widest radix
        program_alphabet(5'd16, "fedcba9876543210");
        send_value(32'h8000_0000);
        send_value(32'hffff_ffff);
        send_value(32'hdead_beef);
        settle();

        // binary: most negative value gives the longest text
        syms = {$urandom(), $urandom(), $urandom(), $urandom()};
        syms[15:0] = "10";
        program_alphabet(5'd2, syms);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'd0);
        settle();

        // printable edges: space and tilde are legal symbols
        program_alphabet(5'd3, "!~ ");
        send_value(-32'sd7);
        settle();

        // sign codes beyond the radix are ignored
        program_alphabet(5'd10, "-+-9876543210");
        send_value(-32'sd1234);
        settle();

        // each kind of bad alphabet swallows the value
        for (int k = FAULT_FEW; k <= FAULT_DUP; k++) begin
            program_faulty(fault_e'(k), 5'($urandom_range(2, 16)));
            send_value(-32'sd1);
            settle();
        end

        // random phases; phase 1 runs without idling, phase 3 also holds the sink off
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            calm   = (phase == 1) || (phase == 3) || ($urandom_range(5) == 0);
            faulty = (phase > 3) && ($urandom_range(3) == 0);
            radix  = 5'($urandom_range(2, 16));
            if (faulty) begin
                program_faulty(fault_e'($urandom_range(FAULT_FEW, FAULT_DUP)), radix);
                count = $urandom_range(2, 6);
            end else begin
                program_alphabet(radix, random_symbols(radix));
                count = $urandom_range(15, 40);
            end
            if (phase == 3) hold_req = 1'b1;
            repeat (count) begin
                send_value(random_value());
                if (!faulty) sent++;
            end
            settle();
            phase++;
        end

        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/rdf_pkg.sv
rtl/radix_digit_formatter_core.sv
test/radix_digit_formatter_core_tb.sv
